// File: src/bflr_pkg.sv
// ============================================================================
// bflr_pkg
// Shared types and constants for the battery fault LED ring pattern block.
// ============================================================================
`default_nettype none

package bflr_pkg;

    // Input transaction kinds.
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_CELL   = 2'd1;
    localparam logic [1:0] KIND_RENDER = 2'd2;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_PERIOD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAD_CELL_MV    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PRESENT_MV = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_LEVEL      = 3'd5;

    localparam logic [6:0]  RST_LED_COUNT      = 7'd16;
    localparam logic [15:0] RST_TOGGLE_PERIOD  = 16'd500;
    localparam logic [6:0]  RST_GROUP_SIZE     = 7'd2;
    localparam logic [15:0] RST_BAD_CELL_MV    = 16'd3000;
    localparam logic [15:0] RST_MIN_PRESENT_MV = 16'd1000;
    localparam logic [7:0]  RST_RED_LEVEL      = 8'd255;

    // Sequential divider widths.
    localparam int DVD_W     = 17;
    localparam int DSR_W     = 16;
    localparam int DIV_CNT_W = 5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] elapsed_ms;
        logic        battery_sel;
        logic [15:0] cell_voltage_mv;
        logic        last_cell;
    } t_in;

    typedef struct packed {
        logic [5:0] led_index;
        logic       paint_red;
        logic [7:0] red_value;
        logic       last_led;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_PREP,
        ST_RENDER
    } t_state;

    typedef struct packed {
        logic tick_start;
        logic tick_done;
        logic cell_upd;
        logic rnd_start;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic n_zero;
        logic last_j;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: src/bflr_div.sv
// ============================================================================
// bflr_div
// Restoring divider, one quotient bit per cycle, shared by the tick and the
// render setup.
// ============================================================================
`default_nettype none

module bflr_div import bflr_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DSR_W-1:0] i_divisor,
    output logic                  o_done,
    output logic                  o_quo_lsb,
    output logic [DSR_W-1:0]      o_rem
);

    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [DVD_W-1:0]     r_quo;
    logic [DSR_W-1:0]     r_rem;
    logic [DSR_W-1:0]     r_dsr;

    logic [DVD_W-1:0]     w_trial;
    logic                 w_qbit;
    logic [DSR_W-1:0]     n_rem;

    // The dividend shifts out at the top while quotient bits shift in below.
    always_comb begin
        w_trial = {r_rem, r_quo[DVD_W-1]};
        w_qbit  = (w_trial >= {1'b0, r_dsr});
        if (w_qbit) begin
            n_rem = DSR_W'(w_trial - {1'b0, r_dsr});
        end else begin
            n_rem = w_trial[DSR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= DIV_CNT_W'(DVD_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DVD_W-2:0], w_qbit};
            r_rem <= n_rem;
        end
    end

    assign o_done    = r_done;
    assign o_quo_lsb = r_quo[0];
    assign o_rem     = r_rem;

endmodule

`default_nettype wire

// File: src/bflr_ctrl.sv
// ============================================================================
// bflr_ctrl
// Controller: accepts input transactions and sequences ticks and renders.
// ============================================================================
`default_nettype none

module bflr_ctrl import bflr_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_in_kind,
    input  wire t_dp_sts    i_sts,
    output logic            o_in_stall,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_kind)
                        KIND_TICK: begin
                            o_cmd.tick_start = 1'b1;
                            n_state          = ST_TICK;
                        end
                        KIND_CELL: begin
                            o_cmd.cell_upd = 1'b1;
                        end
                        KIND_RENDER: begin
                            // An empty ring renders nothing.
                            if (!i_sts.n_zero) begin
                                o_cmd.rnd_start = 1'b1;
                                n_state         = ST_PREP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_TICK: begin
                if (i_sts.div_done) begin
                    o_cmd.tick_done = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            ST_PREP: begin
                if (i_sts.div_done) begin
                    n_state = ST_RENDER;
                end
            end
            ST_RENDER: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last_j) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: src/bflr_dp.sv
// ============================================================================
// bflr_dp
// Datapath: configuration registers, blink timer, fault flags, segment
// trackers for both arcs and the output register.
// ============================================================================
`default_nettype none

module bflr_dp import bflr_pkg::*; #(
    parameter int MAX_LEDS = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_in                   i_in,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts,
    input  wire logic                  i_out_stall,
    output logic                       o_out_valid,
    output t_out                       o_out
);

    // Configuration registers.
    logic [6:0]  r_led_count;
    logic [15:0] r_period;
    logic [6:0]  r_group;
    logic [15:0] r_bad_mv;
    logic [15:0] r_pres_mv;
    logic [7:0]  r_red;

    // Block state.
    logic [15:0] r_accum;
    logic        r_phase;
    logic [1:0]  r_fault;
    logic [1:0]  r_bad_seen;
    logic [1:0]  r_pres_seen;

    // Render walk.
    logic [6:0]  r_j;
    logic [9:0]  r_r0;
    logic        r_p0;
    logic [9:0]  r_r1;
    logic        r_p1;

    logic        r_out_valid;
    t_out        r_out;

    logic [6:0]        w_n;
    logic [6:0]        w_g;
    logic [9:0]        w_seg;
    logic [15:0]       w_period;
    logic [DVD_W-1:0]  w_sum;
    logic              w_div_start;
    logic [DVD_W-1:0]  w_dividend;
    logic [DSR_W-1:0]  w_divisor;
    logic              w_div_done;
    logic              w_quo_lsb;
    logic [DSR_W-1:0]  w_rem;

    logic [9:0]  w_x0;
    logic [9:0]  w_2n;
    logic [10:0] w_x1;
    logic        w_in0;
    logic        w_in1;
    logic        w_first1;
    logic [9:0]  w_r1_eff;
    logic        w_p1_eff;
    logic [10:0] w_step0;
    logic [10:0] w_step1;
    logic        w_paint;
    logic        w_last;
    logic        w_cell_bad;
    logic        w_cell_pres;

    // Advance a segment position by one LED (four quarter units) and flip the
    // parity whenever a segment boundary is crossed. Returns {parity, pos}.
    function automatic logic [10:0] f_step(input logic [9:0] pos, input logic par,
                                           input logic [9:0] seg);
        logic [10:0] sum;
        logic [10:0] res;
        sum = {1'b0, pos} + 11'd4;
        if (sum >= {1'b0, seg}) begin
            res = {~par, 10'(sum - {1'b0, seg})};
        end else begin
            res = {par, sum[9:0]};
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count <= RST_LED_COUNT;
            r_period    <= RST_TOGGLE_PERIOD;
            r_group     <= RST_GROUP_SIZE;
            r_bad_mv    <= RST_BAD_CELL_MV;
            r_pres_mv   <= RST_MIN_PRESENT_MV;
            r_red       <= RST_RED_LEVEL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LED_COUNT:      r_led_count <= i_cfg_data[6:0];
                CFG_TOGGLE_PERIOD:  r_period    <= i_cfg_data;
                CFG_GROUP_SIZE:     r_group     <= i_cfg_data[6:0];
                CFG_BAD_CELL_MV:    r_bad_mv    <= i_cfg_data;
                CFG_MIN_PRESENT_MV: r_pres_mv   <= i_cfg_data;
                CFG_RED_LEVEL:      r_red       <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (32'(r_led_count) > MAX_LEDS) begin
            w_n = 7'(MAX_LEDS);
        end else begin
            w_n = r_led_count;
        end
        w_g      = (r_group == 7'd0) ? 7'd1 : r_group;
        w_seg    = {1'b0, w_g, 2'b00};
        w_period = (r_period == 16'd0) ? 16'd1 : r_period;
        w_sum    = {1'b0, r_accum} + {1'b0, i_in.elapsed_ms};
    end

    // A tick divides the accumulated time by the period. A render divides the
    // wrapped position of LED 0 in the second arc by the segment width.
    assign w_div_start = i_cmd.tick_start | i_cmd.rnd_start;
    assign w_dividend  = i_cmd.tick_start ? w_sum : {9'd0, w_n, 1'b0};
    assign w_divisor   = i_cmd.tick_start ? w_period : {6'd0, w_seg};

    bflr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quo_lsb  (w_quo_lsb),
        .o_rem      (w_rem)
    );

    // Arc 0 covers LEDs whose offset 4j stays within 2N. Arc 1 covers LED 0
    // through the wrap, then every LED with 4j at or above 2N.
    always_comb begin
        w_x0     = {1'b0, r_j, 2'b00};
        w_2n     = {2'b00, w_n, 1'b0};
        w_x1     = {1'b0, w_x0} - {1'b0, w_2n};
        w_in0    = (w_x0 <= w_2n);
        w_in1    = (r_j == 7'd0) || !w_x1[10];
        w_first1 = !w_x1[10] && (w_x1[9:2] == 8'd0);
        if (w_first1) begin
            w_r1_eff = w_x1[9:0];
            w_p1_eff = 1'b0;
        end else begin
            w_r1_eff = r_r1;
            w_p1_eff = r_p1;
        end
        if (r_j == 7'd0) begin
            w_p1_eff = w_quo_lsb;
        end
        w_step0 = f_step(r_r0, r_p0, w_seg);
        w_step1 = f_step(w_r1_eff, w_p1_eff, w_seg);
        // An even segment is red when the phase is clear, an odd one when set.
        w_paint = (r_fault[0] && w_in0 && (r_p0 == r_phase)) ||
                  (r_fault[1] && w_in1 && (w_p1_eff == r_phase));
        w_last  = (({1'b0, r_j} + 8'd1) == {1'b0, w_n});
    end

    assign w_cell_bad  = (i_in.cell_voltage_mv < r_bad_mv);
    assign w_cell_pres = (i_in.cell_voltage_mv >= r_pres_mv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum     <= '0;
            r_phase     <= 1'b0;
            r_fault     <= '0;
            r_bad_seen  <= '0;
            r_pres_seen <= '0;
        end else begin
            if (i_cmd.tick_done) begin
                r_accum <= w_rem;
                r_phase <= r_phase ^ w_quo_lsb;
            end
            if (i_cmd.cell_upd) begin
                if (i_in.last_cell) begin
                    r_fault[i_in.battery_sel]     <=
                        (r_bad_seen[i_in.battery_sel] | w_cell_bad) &
                        (r_pres_seen[i_in.battery_sel] | w_cell_pres);
                    r_bad_seen[i_in.battery_sel]  <= 1'b0;
                    r_pres_seen[i_in.battery_sel] <= 1'b0;
                end else begin
                    r_bad_seen[i_in.battery_sel]  <=
                        r_bad_seen[i_in.battery_sel] | w_cell_bad;
                    r_pres_seen[i_in.battery_sel] <=
                        r_pres_seen[i_in.battery_sel] | w_cell_pres;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rnd_start) begin
            r_j  <= '0;
            r_r0 <= '0;
            r_p0 <= 1'b0;
            r_r1 <= '0;
            r_p1 <= 1'b0;
        end else if (i_cmd.emit) begin
            r_j  <= r_j + 1'b1;
            r_r0 <= w_step0[9:0];
            r_p0 <= w_step0[10];
            r_r1 <= w_step1[9:0];
            r_p1 <= w_step1[10];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.led_index <= r_j[5:0];
            r_out.paint_red <= w_paint;
            r_out.red_value <= w_paint ? r_red : 8'd0;
            r_out.last_led  <= w_last;
        end
    end

    always_comb begin
        o_sts.div_done = w_div_done;
        o_sts.n_zero   = (w_n == 7'd0);
        o_sts.last_j   = w_last;
        o_sts.out_free = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// File: src/battery_fault_led_ring_pattern.sv
// ============================================================================
// battery_fault_led_ring_pattern
// Blinking fault pattern for an LED ring shared by two batteries.
// ============================================================================
//
//  Channel   Valid        Stall        Payload       Direction
//  input     i_in_valid   o_in_stall   i_in  (t_in)  tick, cell report, render
//  output    o_out_valid  i_out_stall  o_out (t_out) one transaction per LED
//  config    i_cfg_we     -            i_cfg_idx, i_cfg_data
//
//  A cell report is taken without a stall. A tick stalls the input while the
//  17-step restoring divider splits the elapsed time into periods.
//  A render first runs the same divider to place LED 0 in the second arc
//  and then emits one LED per cycle while the output is not stalled.
//  A stalled output holds its transaction; the walk waits behind it.
//  Reset is synchronous and restores the register defaults and clears all
//  fault and blink state.
//
`default_nettype none

module battery_fault_led_ring_pattern import bflr_pkg::*; #(
    parameter int MAX_LEDS = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in                   i_in,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out                       o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    bflr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_kind  (i_in.kind),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    bflr_dp #(
        .MAX_LEDS (MAX_LEDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// File: src/bflr_chk.sv
// ============================================================================
// bflr_chk
// Port-level checks on the battery fault LED ring pattern block.
// ============================================================================
`default_nettype none

module bflr_chk import bflr_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_stall,
    input wire t_in                   i_in,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_stall,
    input wire t_out                  o_out,
    input wire logic                  i_cfg_we,
    input wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // A stalled output transaction stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled output transaction changed");

    // A tick keeps the block busy while the divider runs.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in.kind == KIND_TICK) |=> o_in_stall)
        else $error("input not stalled after a tick");

    // A cell report completes in its own cycle.
    a_cell_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in.kind == KIND_CELL) |=> !o_in_stall)
        else $error("input stalled after a cell report");

    // While a render run is still pending its last LED, no input is taken.
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.last_led |-> o_in_stall)
        else $error("input accepted in the middle of a render run");

    // Reset leaves no output transaction.
    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind battery_fault_led_ring_pattern bflr_chk u_bflr_chk (.*);

`default_nettype wire

// File: tb/battery_fault_led_ring_pattern_tb.sv
// ============================================================================
// battery_fault_led_ring_pattern_tb
// Self-checking bench for the battery fault LED ring pattern block. A queue
// of pending ticks, cell reports and render requests feeds a clocked driver.
// A clocked monitor predicts the LED transactions of every accepted render
// and compares each LED transaction, field by field, with the oldest
// prediction. Directed items cover thresholds, blink wrap and size corner
// cases. Random phases follow with several register settings, both idling
// profiles and one long output hold-off.
// ============================================================================
`default_nettype none

module battery_fault_led_ring_pattern_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bflr_pkg::*;

    localparam int          RING_MAX       = 64;
    localparam int          DRAIN_CYCLES   = 40;
    // A tick or render setup runs the divider and a full render emits 64 LED
    // transactions, each of which can wait out a random stall streak. Even the
    // forced hold-off leaves a wide margin below this limit.
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam logic [1:0]  KIND_UNUSED    = 2'd3;

    typedef enum logic [1:0] {
        IDLE_SENDER_LIGHT,
        IDLE_SENDER_HEAVY,
        IDLE_NONE
    } t_idle_mode;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in                   i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out                  o_out;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    battery_fault_led_ring_pattern #(
        .MAX_LEDS (RING_MAX)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Register copies and pattern state of the predictor.
    logic [6:0]  cfg_led_count;
    logic [15:0] cfg_period_ms;
    logic [6:0]  cfg_group;
    logic [15:0] cfg_bad_mv;
    logic [15:0] cfg_present_mv;
    logic [7:0]  cfg_red;
    logic [15:0] accum_ms;
    logic        blink;
    logic [1:0]  fault_flag;
    logic [1:0]  bad_flag;
    logic [1:0]  present_flag;

    t_out        led_expect[$];
    t_in         item_backlog[$];
    t_idle_mode  idle_mode      = IDLE_SENDER_LIGHT;
    int          hold_left      = 0;
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    logic        in_fire        = 1'b0;

    function automatic void ring_reset();
        cfg_led_count  = RST_LED_COUNT;
        cfg_period_ms  = RST_TOGGLE_PERIOD;
        cfg_group      = RST_GROUP_SIZE;
        cfg_bad_mv     = RST_BAD_CELL_MV;
        cfg_present_mv = RST_MIN_PRESENT_MV;
        cfg_red        = RST_RED_LEVEL;
        accum_ms       = '0;
        blink          = 1'b0;
        fault_flag     = '0;
        bad_flag       = '0;
        present_flag   = '0;
    endfunction

    // Positions are in quarter-LED units; the offset from the arc centre is
    // wrapped around the ring before the arc bounds are applied.
    function automatic bit segment_red(int j, int n, int centre, int g);
        int d;
        int seg;
        d = 4 * j - centre;
        if (d < -2 * n)
            d += 4 * n;
        if (d >= 2 * n)
            d -= 4 * n;
        if (d > n || d < -n)
            return 1'b0;
        seg = (d + n) / (4 * g);
        return ((seg % 2) == 0) != blink;
    endfunction

    function automatic void ring_predict(t_in item);
        int   period;
        int   total;
        int   n;
        int   g;
        bit   paint;
        t_out res;
        logic b;
        case (item.kind)
            KIND_TICK: begin
                period   = (cfg_period_ms == 0) ? 1 : int'(cfg_period_ms);
                total    = int'(accum_ms) + int'(item.elapsed_ms);
                blink    = blink ^ ((total / period) % 2 != 0);
                accum_ms = 16'(total % period);
            end
            KIND_CELL: begin
                b = item.battery_sel;
                if (item.cell_voltage_mv < cfg_bad_mv)
                    bad_flag[b] = 1'b1;
                if (item.cell_voltage_mv >= cfg_present_mv)
                    present_flag[b] = 1'b1;
                if (item.last_cell) begin
                    fault_flag[b]   = bad_flag[b] & present_flag[b];
                    bad_flag[b]     = 1'b0;
                    present_flag[b] = 1'b0;
                end
            end
            KIND_RENDER: begin
                n = (cfg_led_count > RING_MAX) ? RING_MAX : int'(cfg_led_count);
                g = (cfg_group == 0) ? 1 : int'(cfg_group);
                for (int j = 0; j < n; j++) begin
                    paint = (fault_flag[0] && segment_red(j, n, n, g))
                         || (fault_flag[1] && segment_red(j, n, 3 * n, g));
                    res.led_index = 6'(j);
                    res.paint_red = paint;
                    res.red_value = paint ? cfg_red : 8'd0;
                    res.last_led  = (j == n - 1);
                    led_expect.push_back(res);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_led(t_out got);
        t_out want;
        if (led_expect.size() == 0) begin
            $error("LED %0d transaction arrived with nothing predicted", got.led_index);
            mismatch_count++;
            return;
        end
        want = led_expect.pop_front();
        if (got.led_index != want.led_index) begin
            $error("led_index expected %0d actual %0d", want.led_index, got.led_index);
            mismatch_count++;
        end
        if (got.paint_red != want.paint_red) begin
            $error("paint_red expected %0d actual %0d", want.paint_red, got.paint_red);
            mismatch_count++;
        end
        if (got.red_value != want.red_value) begin
            $error("red_value expected %0d actual %0d", want.red_value, got.red_value);
            mismatch_count++;
        end
        if (got.last_led != want.last_led) begin
            $error("last_led expected %0d actual %0d", want.last_led, got.last_led);
            mismatch_count++;
        end
    endfunction

    function automatic bit sender_rests();
        case (idle_mode)
            IDLE_SENDER_LIGHT: return $urandom_range(99) < 12;
            IDLE_SENDER_HEAVY: return $urandom_range(99) < 60;
            default:           return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_rests();
        case (idle_mode)
            IDLE_SENDER_LIGHT: return $urandom_range(99) < 60;
            IDLE_SENDER_HEAVY: return $urandom_range(99) < 12;
            default:           return 1'b0;
        endcase
    endfunction

    // Fields that the kind does not use still carry random bits.
    function automatic t_in make_item(logic [1:0] kind);
        logic [63:0] raw;
        t_in         item;
        raw       = {$urandom, $urandom};
        item      = raw[$bits(t_in)-1:0];
        item.kind = kind;
        return item;
    endfunction

    function automatic void add_tick(logic [15:0] ms);
        t_in item;
        item            = make_item(KIND_TICK);
        item.elapsed_ms = ms;
        item_backlog.push_back(item);
    endfunction

    function automatic void add_cell(logic b, logic [15:0] mv, logic last);
        t_in item;
        item                 = make_item(KIND_CELL);
        item.battery_sel     = b;
        item.cell_voltage_mv = mv;
        item.last_cell       = last;
        item_backlog.push_back(item);
    endfunction

    function automatic void add_render();
        item_backlog.push_back(make_item(KIND_RENDER));
    endfunction

    // Most voltages land close to one of the two thresholds.
    function automatic logic [15:0] pick_mv();
        int r;
        int base;
        r = $urandom_range(99);
        if (r < 30)
            return 16'($urandom);
        base = (r < 65) ? int'(cfg_bad_mv) : int'(cfg_present_mv);
        base += int'($urandom_range(100)) - 50;
        if (base < 0)
            base = 0;
        if (base > 65535)
            base = 65535;
        return 16'(base);
    endfunction

    function automatic logic [15:0] pick_ms();
        int span;
        if ($urandom_range(1) == 0)
            return 16'($urandom);
        span = 2 * int'(cfg_period_ms);
        if (span > 65535)
            span = 65535;
        return 16'($urandom_range(span));
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_LED_COUNT:      cfg_led_count  = value[6:0];
            CFG_TOGGLE_PERIOD:  cfg_period_ms  = value;
            CFG_GROUP_SIZE:     cfg_group      = value[6:0];
            CFG_BAD_CELL_MV:    cfg_bad_mv     = value;
            CFG_MIN_PRESENT_MV: cfg_present_mv = value;
            CFG_RED_LEVEL:      cfg_red        = value[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic cfg_all(int leds, int period, int group, int bad, int present, int red);
        cfg_write(CFG_LED_COUNT, 16'(leds));
        cfg_write(CFG_TOGGLE_PERIOD, 16'(period));
        cfg_write(CFG_GROUP_SIZE, 16'(group));
        cfg_write(CFG_BAD_CELL_MV, 16'(bad));
        cfg_write(CFG_MIN_PRESENT_MV, 16'(present));
        cfg_write(CFG_RED_LEVEL, 16'(red));
    endtask

    task automatic cfg_random();
        cfg_all($urandom_range(1, RING_MAX), $urandom_range(1, 1500), $urandom_range(1, 8),
                $urandom_range(2000, 4000), $urandom_range(500, 1500), $urandom_range(255));
    endtask

    // Waits until every item is taken and every LED transaction has arrived,
    // then lets a tick still in its divider run out.
    task automatic settle();
        do
            @(negedge i_clk);
        while (item_backlog.size() != 0 || i_in_valid || led_expect.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Battery reports of one to six cells make up most of the traffic; stray
    // cells and the unused kind are mixed in as noise.
    task automatic fill_random(int count);
        int   made;
        int   r;
        int   cells;
        logic b;
        made = 0;
        @(posedge i_clk);
        while (made < count) begin
            r = $urandom_range(99);
            if (r < 45) begin
                b     = 1'($urandom_range(1));
                cells = $urandom_range(1, 6);
                for (int k = 0; k < cells; k++)
                    add_cell(b, pick_mv(), k == cells - 1);
                made += cells;
            end else if (r < 65) begin
                add_tick(pick_ms());
                made++;
            end else if (r < 88) begin
                add_render();
                made++;
            end else if (r < 95) begin
                add_cell(1'($urandom_range(1)), pick_mv(), 1'($urandom_range(1)));
                made++;
            end else begin
                item_backlog.push_back(make_item(KIND_UNUSED));
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && !in_fire)) begin
            if (item_backlog.size() != 0 && !sender_rests()) begin
                i_in       <= item_backlog.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_out_stall <= receiver_rests();
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall)
                ring_predict(i_in);
            if (o_out_valid && !i_out_stall)
                check_led(o_out);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        ring_reset();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: threshold edges, blink flips and overlapping arcs.
        idle_mode = IDLE_SENDER_LIGHT;
        @(posedge i_clk);
        add_render();
        add_cell(1'b0, 16'd2500, 1'b0);
        add_cell(1'b0, 16'd3500, 1'b1);
        add_render();
        add_tick(16'd500);
        add_render();
        add_cell(1'b1, 16'd0, 1'b0);
        add_cell(1'b1, 16'hFFFF, 1'b1);
        add_render();
        item_backlog.push_back(make_item(KIND_UNUSED));
        add_tick(16'hFFFF);
        add_render();
        add_cell(1'b0, 16'd4000, 1'b1);
        add_cell(1'b1, 16'd100, 1'b1);
        add_render();
        add_tick(16'd0);
        add_tick(16'd400);
        settle();

        // Lowering the period below the accumulator folds many periods into one tick.
        cfg_write(CFG_TOGGLE_PERIOD, 16'd3);
        @(posedge i_clk);
        add_tick(16'd0);
        add_cell(1'b0, 16'd2999, 1'b0);
        add_cell(1'b0, 16'd3000, 1'b1);
        add_cell(1'b1, 16'd999, 1'b0);
        add_cell(1'b1, 16'd1000, 1'b1);
        add_render();
        settle();

        cfg_write(CFG_LED_COUNT, 16'd0);
        @(posedge i_clk);
        add_render();
        settle();

        cfg_write(CFG_LED_COUNT, 16'd127);
        cfg_write(CFG_GROUP_SIZE, 16'd0);
        @(posedge i_clk);
        add_render();
        settle();

        cfg_write(CFG_TOGGLE_PERIOD, 16'd0);
        cfg_write(CFG_GROUP_SIZE, 16'd64);
        cfg_write(CFG_LED_COUNT, 16'd5);
        @(posedge i_clk);
        add_tick(16'd7);
        add_render();
        settle();

        cfg_random();
        fill_random(110);
        settle();

        idle_mode = IDLE_SENDER_HEAVY;
        cfg_all(64, 65535, 64, 65535, 0, 0);
        fill_random(50);
        settle();

        cfg_all(1, 1, 1, 0, 65535, 1);
        fill_random(40);
        settle();

        cfg_random();
        fill_random(50);
        settle();

        // The receiver holds off while renders keep coming, so the block
        // backs up and stalls its input.
        idle_mode = IDLE_NONE;
        cfg_all(64, 300, 3, 3000, 1000, 200);
        @(posedge i_clk);
        hold_left = 400;
        add_cell(1'b0, 16'd2000, 1'b1);
        repeat (12) begin
            add_render();
            add_tick(16'd150);
        end
        settle();

        cfg_random();
        fill_random(80);
        settle();

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
